FILE: sv/sid2a_pkg.sv
// Shared types and character constants for the signed integer to decimal
// ASCII unit. No dependencies.
package sid2a_pkg;

    localparam int CHAR_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CONVERT = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_SIGN    = 5'b01000,
        ST_DIGITS  = 5'b10000
    } state_t;

endpackage

FILE: sv/sid2a_bcd_cell.sv
// One decimal digit cell of the binary to BCD shift chain (add-3 and shift).
// Standalone; chained by signed_int_to_decimal_ascii_unit.
module sid2a_bcd_cell
(
    input  logic       clk,
    input  logic       clear,
    input  logic       shift,
    input  logic       carry_in,
    output logic       carry_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (clear)
        begin
            digit_next = 4'd0;
        end
        else if (shift)
        begin
            digit_next = {adj[2:0], carry_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign carry_out = adj[3];
    assign digit     = digit_reg;

endmodule

FILE: sv/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII unit.
// Depends on sid2a_pkg and sid2a_bcd_cell.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one signed integer per
//   transfer in s_tdata[VALUE_WIDTH-1:0]. Master channel (m_tvalid/m_tready/
//   m_tdata/m_tlast) returns its decimal text, one ASCII character per
//   transfer in m_tdata[5:0], most significant character first: a minus sign
//   for negative values, then the digits with leading zeros dropped. m_tlast
//   marks the final character of each number.
//   The magnitude is shifted one bit per cycle through a chain of BCD digit
//   cells, after which a scan state locates the leading digit. Characters
//   then leave at one per cycle while m_tready is high.
//   One number is handled at a time: the next value is not accepted until
//   the final character of the current one has been taken.
//   s_tready is high only while the unit is idle.
//   When the receiver stalls, the current character holds on m_tdata and
//   m_tlast until it is taken.
//   Reset returns the unit to idle and drops any number in progress.
module signed_int_to_decimal_ascii_unit
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // text_char, zero padded
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast
);

    localparam int NUM_DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    sid2a_pkg::state_t state_reg;
    sid2a_pkg::state_t state_next;

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic                   neg_reg;
    logic                   neg_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_xfer;
    logic                   out_xfer;
    logic                   cell_clear;
    logic                   cell_shift;
    logic [3:0]             digits [NUM_DIGITS];
    logic [NUM_DIGITS:0]    carry;
    logic [IDX_W-1:0]       msd;
    logic [sid2a_pkg::CHAR_W-1:0] text_char;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    assign cell_clear = in_xfer;
    assign cell_shift = (state_reg == sid2a_pkg::ST_CONVERT);
    assign carry[0]   = mag_reg[VALUE_WIDTH-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            sid2a_bcd_cell u_cell
            (
                .clk       (clk),
                .clear     (cell_clear),
                .shift     (cell_shift),
                .carry_in  (carry[g]),
                .carry_out (carry[g+1]),
                .digit     (digits[g])
            );
        end
    endgenerate

    always_comb
    begin
        msd = '0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (digits[i] != 4'd0)
            begin
                msd = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        case (state_reg)
            sid2a_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next   = in_value[VALUE_WIDTH-1];
                    mag_next   = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
                    cnt_next   = CNT_W'(VALUE_WIDTH - 1);
                    state_next = sid2a_pkg::ST_CONVERT;
                end
            end
            sid2a_pkg::ST_CONVERT:
            begin
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = sid2a_pkg::ST_SCAN;
                end
            end
            sid2a_pkg::ST_SCAN:
            begin
                idx_next   = msd;
                state_next = neg_reg ? sid2a_pkg::ST_SIGN : sid2a_pkg::ST_DIGITS;
            end
            sid2a_pkg::ST_SIGN:
            begin
                idx_next = msd;
                if (out_xfer)
                begin
                    state_next = sid2a_pkg::ST_DIGITS;
                end
            end
            sid2a_pkg::ST_DIGITS:
            begin
                if (out_xfer)
                begin
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = sid2a_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sid2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sid2a_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        neg_reg <= neg_next;
    end

    assign text_char = (state_reg == sid2a_pkg::ST_SIGN)
                     ? sid2a_pkg::CHAR_MINUS
                     : (sid2a_pkg::CHAR_ZERO + {2'b00, digits[idx_reg]});

    assign s_tready = (state_reg == sid2a_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sid2a_pkg::ST_SIGN) || (state_reg == sid2a_pkg::ST_DIGITS);
    assign m_tdata  = {2'b00, text_char};
    assign m_tlast  = (state_reg == sid2a_pkg::ST_DIGITS) && (idx_reg == '0);

endmodule

FILE: tb/signed_int_to_decimal_ascii_unit_test.sv
`timescale 1ns / 100ps
// Testbench for signed_int_to_decimal_ascii_unit: predicts the decimal text of
// every accepted integer and checks each character transfer against it.
// Depends on sid2a_pkg and the unit's RTL.
module signed_int_to_decimal_ascii_unit_test;

    localparam int VALUE_W     = 32;
    localparam int HOLD_CYCLES = 400;

    localparam int EDGE_VALUES [24] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
        2147483647, -2147483647, 32'h8000_0000, 2147483646,
        1000000000, -1000000000, 999999999, -999999999, 1000000001,
        12345, -67890, 32'h5555_5555, 32'hAAAA_AAAA, 7
    };

    typedef struct packed {
        logic [sid2a_pkg::CHAR_W-1:0] code;
        logic                         last;
    } text_char_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;
    logic               m_tlast;

    logic [VALUE_W-1:0] value_q [$];
    text_char_t         text_q [$];
    int                 values_queued = 0;
    int                 values_taken  = 0;
    int                 error_cnt     = 0;
    int                 src_idle_pct  = 0;
    int                 sink_idle_pct = 0;
    logic               hold_start    = 1'b0;
    logic               rx_hold       = 1'b0;
    int                 hold_cnt      = 0;
    logic               in_fire       = 1'b0;

    signed_int_to_decimal_ascii_unit #(
        .VALUE_WIDTH (VALUE_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #1_000_000;
        $display("signed_int_to_decimal_ascii_unit_test: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        error_cnt++;
    endtask

    function automatic void push_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit_buf [0:20];
        text_char_t         tc;
        int                 n;
        n   = 0;
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        do
        begin
            digit_buf[n] = 4'(mag % 10);
            mag          = mag / 10;
            n++;
        end
        while (mag != 0);
        if (value[VALUE_W-1])
        begin
            tc.code = sid2a_pkg::CHAR_MINUS;
            tc.last = 1'b0;
            text_q.push_back(tc);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            tc.code = sid2a_pkg::CHAR_ZERO + sid2a_pkg::CHAR_W'(digit_buf[i]);
            tc.last = (i == 0);
            text_q.push_back(tc);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        longint unsigned    scale;
        int                 digits;
        scale = 1;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                v = $urandom;
            end
            4, 5, 6:
            begin
                digits = $urandom_range(1, 10);
                repeat (digits) scale = scale * 10;
                v = VALUE_W'({$urandom, $urandom} % scale);
                if ($urandom_range(1))
                    v = -v;
            end
            7:
            begin
                digits = $urandom_range(0, 9);
                repeat (digits) scale = scale * 10;
                v = VALUE_W'(scale) + $urandom_range(2) - 1;
                if ($urandom_range(1))
                    v = -v;
            end
            8:
            begin
                case ($urandom_range(3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h8000_0001;
                    default: v = 32'h7FFF_FFFE;
                endcase
            end
            default:
            begin
                v = $urandom_range(40) - 20;
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        value_q.push_back(v);
        values_queued++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_value(random_value());
    endtask

    task automatic wait_drained();
        while (values_taken != values_queued || text_q.size() != 0)
            @(negedge clk);
    endtask

    // driver: hold tvalid until the transfer, then offer the next value
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (value_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tdata  <= value_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= rst_n && !rx_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (hold_start)
        begin
            rx_hold  <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else
        begin
            rx_hold <= 1'b0;
        end
    end

    // monitor: check character transfers, then queue text for new values
    always @(posedge clk)
    begin
        text_char_t tc;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (text_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h", m_tdata));
            end
            else
            begin
                tc = text_q.pop_front();
                if (m_tdata !== {2'b00, tc.code})
                    report_mismatch($sformatf("text_char got 0x%02h want 0x%02h",
                                              m_tdata, {2'b00, tc.code}));
                if (m_tlast !== tc.last)
                    report_mismatch($sformatf("last_char got %b want %b",
                                              m_tlast, tc.last));
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            push_decimal_text(s_tdata);
            values_taken++;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (EDGE_VALUES[i])
            send_value(EDGE_VALUES[i]);
        wait_drained();

        src_idle_pct  = 32;
        sink_idle_pct = 48;
        send_random(100);
        wait_drained();

        // stall the receiver while the sender keeps offering values
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_start    = 1'b1;
        @(negedge clk);
        hold_start    = 1'b0;
        send_random(6);
        wait_drained();

        src_idle_pct  = 48;
        sink_idle_pct = 32;
        send_random(100);
        wait_drained();

        // pause the sender mid-phase until all text is out
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random(50);
        wait_drained();
        send_random(50);
        wait_drained();

        repeat (60) @(posedge clk);
        if (error_cnt == 0)
            $display("signed_int_to_decimal_ascii_unit_test: done, clean");
        else
            $display("signed_int_to_decimal_ascii_unit_test: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/sid2a_pkg.sv
sv/sid2a_bcd_cell.sv
sv/signed_int_to_decimal_ascii_unit.sv
tb/signed_int_to_decimal_ascii_unit_test.sv
